// ----- hdl/assert_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros used by the sender top level to check its own logic.
// Every check is clocked on the rising edge and is disabled while the
// active-low reset is asserted.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge.
`define ARQ_ASSERT(name, clk, rst_n, prop, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// A condition in one cycle that implies a consequence in the next cycle.
`define ARQ_ASSERT_NEXT(name, clk, rst_n, trig, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/arq_pkg.sv -----
// ---------------------------------------------------------------------------
// arq_pkg
// Types and codes shared by the stop-and-wait ARQ sender modules.
// ---------------------------------------------------------------------------
package arq_pkg;

    // Command codes of an input item.
    localparam logic [1:0] CMD_START = 2'd0;
    localparam logic [1:0] CMD_ACK   = 2'd1;
    localparam logic [1:0] CMD_TICK  = 2'd2;

    // Result kinds.
    localparam logic [1:0] KIND_SEND = 2'd0;
    localparam logic [1:0] KIND_DONE = 2'd1;
    localparam logic [1:0] KIND_ERR  = 2'd2;

    // Sender phase codes.
    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_RUN  = 2'd1;
    localparam logic [1:0] PH_STOP = 2'd2;

    // Configuration register indexes.
    localparam logic REG_STREAM_LENGTH = 1'b0;
    localparam logic REG_TIMEOUT_TICKS = 1'b1;

    // Reset value of the timeout register.
    localparam logic [15:0] TIMEOUT_RESET = 16'd1000;

    // One input item.
    typedef struct packed {
        logic [1:0]  command;
        logic        ack_channel;
        logic        ack_type_ok;
        logic [31:0] ack_seq;
    } in_item_t;

    // One result item.
    typedef struct packed {
        logic [1:0]  kind;
        logic        channel;
        logic [31:0] seq_offset;
        logic [10:0] segment_bytes;
        logic        final_segment;
        logic        resend;
        logic        last_of_run;
    } result_t;

    // One configuration write.
    typedef struct packed {
        logic        index;
        logic [31:0] value;
    } cfg_write_t;

    // Up to two results produced by one input item.
    typedef struct packed {
        logic [1:0]           count;
        result_t [1:0]        res;
    } result_pair_t;

endpackage

// ----- hdl/arq_chan_if.sv -----
// ---------------------------------------------------------------------------
// arq_chan_if
// Valid/ready channel that carries one item of payload type T.
// ---------------------------------------------------------------------------
interface arq_chan_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (
        output valid,
        output data,
        input  ready
    );

    modport sink (
        input  valid,
        input  data,
        output ready
    );
endinterface

// ----- hdl/arq_engine.sv -----
// ---------------------------------------------------------------------------
// arq_engine
// Sender state and the single-pass next-state logic. For the registered
// input item it computes up to two results and, on fire, commits the state.
// ---------------------------------------------------------------------------
module arq_engine
    import arq_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 1024
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         fire,
    input  in_item_t     item,
    input  logic [31:0]  stream_length,
    input  logic [15:0]  timeout_ticks,
    output result_pair_t pair
);

    localparam logic [31:0] PB32 = 32'(PAYLOAD_BYTES);

    logic [1:0]  phase_reg, phase_next;
    logic [31:0] next_offset_reg, next_offset_next;
    logic        busy_reg [2];
    logic        busy_next [2];
    logic [31:0] seq_reg [2];
    logic [31:0] seq_next [2];
    logic [10:0] len_reg [2];
    logic [10:0] len_next [2];
    logic        final_reg [2];
    logic        final_next [2];
    logic [15:0] timer_reg [2];
    logic [15:0] timer_next [2];

    // Segment cut at the start offset and after a full first segment.
    logic [31:0] start_len_a;
    logic        start_full_a;
    logic [31:0] rem_b;
    logic        full_b;
    logic [31:0] start_len_b;

    // Segment cut at the current next offset on an acknowledgement.
    logic [31:0] rem_n;
    logic        full_n;
    logic [31:0] len_n;
    logic        more;

    // Acknowledgement check and timer expiry.
    logic        ach;
    logic        ack_bad;
    logic        exp0;
    logic        exp1;

    assign start_full_a = stream_length > PB32;
    assign start_len_a  = start_full_a ? PB32 : stream_length;
    assign rem_b        = stream_length - PB32;
    assign full_b       = rem_b > PB32;
    assign start_len_b  = full_b ? PB32 : rem_b;

    assign more   = next_offset_reg < stream_length;
    assign rem_n  = stream_length - next_offset_reg;
    assign full_n = rem_n > PB32;
    assign len_n  = full_n ? PB32 : rem_n;

    assign ach     = item.ack_channel;
    assign ack_bad = !busy_reg[ach] || !item.ack_type_ok || (item.ack_seq != seq_reg[ach]);
    assign exp0    = busy_reg[0] && (timer_reg[0] <= 16'd1);
    assign exp1    = busy_reg[1] && (timer_reg[1] <= 16'd1);

    // Next state and results for the item in the input register.
    always_comb
    begin
        phase_next       = phase_reg;
        next_offset_next = next_offset_reg;
        busy_next        = busy_reg;
        seq_next         = seq_reg;
        len_next         = len_reg;
        final_next       = final_reg;
        timer_next       = timer_reg;
        pair             = '0;

        case (item.command)
            CMD_START:
            begin
                if (phase_reg != PH_RUN)
                begin
                    busy_next[0]     = 1'b0;
                    busy_next[1]     = 1'b0;
                    timer_next[0]    = '0;
                    timer_next[1]    = '0;
                    next_offset_next = '0;
                    if (stream_length == '0)
                    begin
                        phase_next       = PH_STOP;
                        pair.count       = 2'd1;
                        pair.res[0].kind = KIND_ERR;
                    end
                    else
                    begin
                        phase_next    = PH_RUN;
                        busy_next[0]  = 1'b1;
                        seq_next[0]   = '0;
                        len_next[0]   = start_len_a[10:0];
                        final_next[0] = !start_full_a;
                        timer_next[0] = timeout_ticks;
                        next_offset_next = start_len_a;
                        pair.count    = 2'd1;
                        pair.res[0].kind          = KIND_SEND;
                        pair.res[0].channel       = 1'b0;
                        pair.res[0].seq_offset    = '0;
                        pair.res[0].segment_bytes = start_len_a[10:0];
                        pair.res[0].final_segment = !start_full_a;
                        if (start_full_a)
                        begin
                            busy_next[1]  = 1'b1;
                            seq_next[1]   = PB32;
                            len_next[1]   = start_len_b[10:0];
                            final_next[1] = !full_b;
                            timer_next[1] = timeout_ticks;
                            next_offset_next = PB32 + start_len_b;
                            pair.count    = 2'd2;
                            pair.res[1].kind          = KIND_SEND;
                            pair.res[1].channel       = 1'b1;
                            pair.res[1].seq_offset    = PB32;
                            pair.res[1].segment_bytes = start_len_b[10:0];
                            pair.res[1].final_segment = !full_b;
                        end
                    end
                end
            end

            CMD_ACK:
            begin
                if (phase_reg == PH_RUN)
                begin
                    if (ack_bad)
                    begin
                        phase_next          = PH_STOP;
                        busy_next[0]        = 1'b0;
                        busy_next[1]        = 1'b0;
                        timer_next[0]       = '0;
                        timer_next[1]       = '0;
                        pair.count          = 2'd1;
                        pair.res[0].kind    = KIND_ERR;
                        pair.res[0].channel = ach;
                    end
                    else if (more)
                    begin
                        // The freed channel carries the next segment.
                        busy_next[ach]   = 1'b1;
                        seq_next[ach]    = next_offset_reg;
                        len_next[ach]    = len_n[10:0];
                        final_next[ach]  = !full_n;
                        timer_next[ach]  = timeout_ticks;
                        next_offset_next = next_offset_reg + len_n;
                        pair.count       = 2'd1;
                        pair.res[0].kind          = KIND_SEND;
                        pair.res[0].channel       = ach;
                        pair.res[0].seq_offset    = next_offset_reg;
                        pair.res[0].segment_bytes = len_n[10:0];
                        pair.res[0].final_segment = !full_n;
                    end
                    else
                    begin
                        busy_next[ach]  = 1'b0;
                        timer_next[ach] = '0;
                        if (!busy_reg[!ach])
                        begin
                            phase_next       = PH_IDLE;
                            pair.count       = 2'd1;
                            pair.res[0].kind = KIND_DONE;
                        end
                    end
                end
            end

            CMD_TICK:
            begin
                if (phase_reg == PH_RUN)
                begin
                    // Count down each busy channel; reload and resend on expiry.
                    if (busy_reg[0])
                    begin
                        timer_next[0] = exp0 ? timeout_ticks : timer_reg[0] - 16'd1;
                    end
                    if (busy_reg[1])
                    begin
                        timer_next[1] = exp1 ? timeout_ticks : timer_reg[1] - 16'd1;
                    end
                    if (exp0)
                    begin
                        pair.res[0].kind          = KIND_SEND;
                        pair.res[0].channel       = 1'b0;
                        pair.res[0].seq_offset    = seq_reg[0];
                        pair.res[0].segment_bytes = len_reg[0];
                        pair.res[0].final_segment = final_reg[0];
                        pair.res[0].resend        = 1'b1;
                    end
                    if (exp1)
                    begin
                        pair.res[exp0].kind          = KIND_SEND;
                        pair.res[exp0].channel       = 1'b1;
                        pair.res[exp0].seq_offset    = seq_reg[1];
                        pair.res[exp0].segment_bytes = len_reg[1];
                        pair.res[exp0].final_segment = final_reg[1];
                        pair.res[exp0].resend        = 1'b1;
                    end
                    pair.count = {1'b0, exp0} + {1'b0, exp1};
                end
            end

            default:
            begin
                pair.count = 2'd0;
            end
        endcase

        // Mark the last result that this item causes.
        if (pair.count == 2'd2)
        begin
            pair.res[1].last_of_run = 1'b1;
        end
        else if (pair.count == 2'd1)
        begin
            pair.res[0].last_of_run = 1'b1;
        end
    end

    // State registers, updated when the item is consumed.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= PH_IDLE;
            next_offset_reg <= '0;
            for (int c = 0; c < 2; c++)
            begin
                busy_reg[c]  <= 1'b0;
                seq_reg[c]   <= '0;
                len_reg[c]   <= '0;
                final_reg[c] <= 1'b0;
                timer_reg[c] <= '0;
            end
        end
        else if (fire)
        begin
            phase_reg       <= phase_next;
            next_offset_reg <= next_offset_next;
            busy_reg        <= busy_next;
            seq_reg         <= seq_next;
            len_reg         <= len_next;
            final_reg       <= final_next;
            timer_reg       <= timer_next;
        end
    end

endmodule

// ----- hdl/arq_result_buf.sv -----
// ---------------------------------------------------------------------------
// arq_result_buf
// Two-slot result register. It loads up to two results at once and hands
// them out one per handshake, head first.
// ---------------------------------------------------------------------------
module arq_result_buf
    import arq_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         load,
    input  result_pair_t pair,
    output logic         space,
    arq_chan_if.source   result_out
);

    result_t     head_reg, head_next;
    result_t     tail_reg, tail_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        pop;

    assign result_out.valid = (cnt_reg != 2'd0);
    assign result_out.data  = head_reg;
    assign pop              = result_out.valid && result_out.ready;

    // New results may enter when the buffer is empty after this cycle.
    assign space = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && pop);

    // Load a new pair or shift the tail forward on a pop.
    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        cnt_next  = cnt_reg;
        if (load)
        begin
            head_next = pair.res[0];
            tail_next = pair.res[1];
            cnt_next  = pair.count;
        end
        else if (pop)
        begin
            head_next = tail_reg;
            cnt_next  = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
        end
        else
        begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        head_reg <= head_next;
        tail_reg <= tail_next;
    end

endmodule

// ----- hdl/two_channel_stop_wait_arq_sender.sv -----
// ---------------------------------------------------------------------------
// two_channel_stop_wait_arq_sender
// Control path of a stop-and-wait ARQ sender that moves a byte stream over
// two channels, one outstanding segment per channel.
// ---------------------------------------------------------------------------
// An accepted item lands in an input register, where the engine works on it
// combinationally. Its results (none, one or two) are loaded into the output
// register when the item is consumed, which waits until they fit there, so the
// first result is shown from the output register and not from the engine.
// The block takes one item per cycle as long as each item gives at most one
// result and the output is taken every cycle; an item that gives two results
// (a start with more than one segment, or a tick on which both channels time
// out) holds the two-slot output register until both are taken. Configuration
// writes are always ready and take effect at the edge that accepts them.
module two_channel_stop_wait_arq_sender
    import arq_pkg::*;
#(
    parameter int PAYLOAD_BYTES = 1024
)
(
    input  logic       clk,
    input  logic       rst_n,
    arq_chan_if.sink   item_in,
    arq_chan_if.source result_out,
    arq_chan_if.sink   cfg
);

    `include "assert_macros.svh"

    logic [31:0]  stream_length_reg;
    logic [15:0]  timeout_ticks_reg;
    logic         in_valid_reg;
    in_item_t     in_data_reg;
    result_pair_t pair;
    logic         buf_space;
    logic         fire;
    logic         load;

    // Configuration registers.
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stream_length_reg <= '0;
            timeout_ticks_reg <= TIMEOUT_RESET;
        end
        else if (cfg.valid)
        begin
            if (cfg.data.index == REG_STREAM_LENGTH)
            begin
                stream_length_reg <= cfg.data.value;
            end
            else if (cfg.data.index == REG_TIMEOUT_TICKS)
            begin
                timeout_ticks_reg <= cfg.data.value[15:0];
            end
        end
    end

    // An item is consumed when its results fit in the output register.
    assign fire          = in_valid_reg && ((pair.count == 2'd0) || buf_space);
    assign load          = fire && (pair.count != 2'd0);
    assign item_in.ready = !in_valid_reg || fire;

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (item_in.ready)
        begin
            in_valid_reg <= item_in.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (item_in.valid && item_in.ready)
        begin
            in_data_reg <= item_in.data;
        end
    end

    arq_engine #(
        .PAYLOAD_BYTES (PAYLOAD_BYTES)
    ) u_engine (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (fire),
        .item          (in_data_reg),
        .stream_length (stream_length_reg),
        .timeout_ticks (timeout_ticks_reg),
        .pair          (pair)
    );

    arq_result_buf u_result_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (load),
        .pair       (pair),
        .space      (buf_space),
        .result_out (result_out)
    );

    // Checks on the input register, the engine and the output register.
    `ARQ_ASSERT(a_count_range, clk, rst_n, pair.count != 2'd3,
                "engine gave more than two results")
    `ARQ_ASSERT_NEXT(a_held_item, clk, rst_n, in_valid_reg && !fire,
                     in_valid_reg && $stable(in_data_reg),
                     "waiting item was lost or changed")
    `ARQ_ASSERT_NEXT(a_pair_shown, clk, rst_n, load && pair.count == 2'd2,
                     result_out.valid && !result_out.data.last_of_run,
                     "first of two results not shown")

endmodule

// ----- dv/testbench.sv -----
// ----------------------------------------------------------------------------
// Testbench for two_channel_stop_wait_arq_sender
// Drives start, acknowledgement and tick items into the sender, writes the
// stream length and timeout registers between phases, and checks every
// result against a cycle-free model of the sender kept in a scoreboard.
// ----------------------------------------------------------------------------
module testbench
    import arq_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          SEGMENT_MAX  = 1024;
    localparam int          CYCLE_LIMIT  = 400000;
    localparam int          SETTLE_TICKS = 6;
    localparam int          REPORT_MAX   = 10;
    localparam logic [1:0]  CMD_UNUSED   = 2'd3;

    // Scoreboard: tracks the sender state and the results still awaited.
    class arq_scoreboard;
        logic [31:0] stream_length;
        logic [15:0] timeout_ticks;
        logic [1:0]  phase;
        logic [31:0] next_offset;
        logic        busy[2];
        logic [31:0] seq_of[2];
        logic [10:0] len_of[2];
        logic        final_of[2];
        logic [15:0] timer[2];
        result_t     awaited[$];
        result_t     burst[$];
        int          errors;

        function new();
            stream_length = '0;
            timeout_ticks = TIMEOUT_RESET;
            phase = PH_IDLE;
            next_offset = '0;
            errors = 0;
            clear_channels();
        endfunction

        function void clear_channels();
            for (int c = 0; c < 2; c++)
            begin
                busy[c] = 1'b0;
                seq_of[c] = '0;
                len_of[c] = '0;
                final_of[c] = 1'b0;
                timer[c] = '0;
            end
        endfunction

        function void emit(logic [1:0] kind, logic ch, logic [31:0] seq,
                           logic [10:0] len, logic fin, logic rs);
            result_t r;
            r.kind = kind;
            r.channel = ch;
            r.seq_offset = seq;
            r.segment_bytes = len;
            r.final_segment = fin;
            r.resend = rs;
            r.last_of_run = 1'b0;
            burst.push_back(r);
        endfunction

        // Cut the next segment and make it outstanding on channel c.
        function void send_segment(int c);
            logic [31:0] remain;
            logic [31:0] seg;
            remain = stream_length - next_offset;
            seg = (remain < SEGMENT_MAX) ? remain : SEGMENT_MAX;
            busy[c] = 1'b1;
            seq_of[c] = next_offset;
            len_of[c] = seg[10:0];
            next_offset = next_offset + seg;
            final_of[c] = (next_offset >= stream_length);
            timer[c] = timeout_ticks;
            emit(KIND_SEND, c[0], seq_of[c], len_of[c], final_of[c], 1'b0);
        endfunction

        function void set_register(cfg_write_t w);
            if (w.index == REG_STREAM_LENGTH)
                stream_length = w.value;
            else
                timeout_ticks = w.value[15:0];
        endfunction

        // Advance the model by one accepted item and queue its results.
        function void apply_item(in_item_t it);
            result_t tail;
            int ch;
            burst.delete();
            ch = int'(it.ack_channel);
            case (it.command)
                CMD_START:
                begin
                    if (phase != PH_RUN)
                    begin
                        clear_channels();
                        next_offset = '0;
                        if (stream_length == 0)
                        begin
                            phase = PH_STOP;
                            emit(KIND_ERR, 1'b0, '0, '0, 1'b0, 1'b0);
                        end
                        else
                        begin
                            phase = PH_RUN;
                            send_segment(0);
                            if (next_offset < stream_length)
                                send_segment(1);
                        end
                    end
                end
                CMD_ACK:
                begin
                    if (phase == PH_RUN)
                    begin
                        if (!busy[ch] || !it.ack_type_ok || it.ack_seq != seq_of[ch])
                        begin
                            phase = PH_STOP;
                            clear_channels();
                            emit(KIND_ERR, it.ack_channel, '0, '0, 1'b0, 1'b0);
                        end
                        else
                        begin
                            busy[ch] = 1'b0;
                            timer[ch] = '0;
                            if (next_offset < stream_length)
                                send_segment(ch);
                            else if (!busy[0] && !busy[1])
                            begin
                                phase = PH_IDLE;
                                emit(KIND_DONE, 1'b0, '0, '0, 1'b0, 1'b0);
                            end
                        end
                    end
                end
                CMD_TICK:
                begin
                    if (phase == PH_RUN)
                    begin
                        for (int c = 0; c < 2; c++)
                        begin
                            if (busy[c])
                            begin
                                if (timer[c] <= 1)
                                begin
                                    timer[c] = timeout_ticks;
                                    emit(KIND_SEND, c[0], seq_of[c], len_of[c],
                                         final_of[c], 1'b1);
                                end
                                else
                                    timer[c] = timer[c] - 1'b1;
                            end
                        end
                    end
                end
                default: ;
            endcase
            if (burst.size() > 0)
            begin
                tail = burst.pop_back();
                tail.last_of_run = 1'b1;
                burst.push_back(tail);
            end
            foreach (burst[i])
                awaited.push_back(burst[i]);
        endfunction

        function string show(result_t r);
            return $sformatf("kind %0d ch %0d seq %h len %0d fin %0d rs %0d last %0d",
                             r.kind, r.channel, r.seq_offset, r.segment_bytes,
                             r.final_segment, r.resend, r.last_of_run);
        endfunction

        function void note_failure(string msg);
            errors++;
            if (errors <= REPORT_MAX)
                $display("%s", msg);
        endfunction

        function void check_result(result_t got);
            result_t want;
            if (awaited.size() == 0)
            begin
                note_failure($sformatf("result with none awaited: %s", show(got)));
                return;
            end
            want = awaited.pop_front();
            if (got.kind !== want.kind || got.channel !== want.channel ||
                got.seq_offset !== want.seq_offset ||
                got.segment_bytes !== want.segment_bytes ||
                got.final_segment !== want.final_segment ||
                got.resend !== want.resend || got.last_of_run !== want.last_of_run)
            begin
                note_failure($sformatf("expected %s", show(want)));
                if (errors <= REPORT_MAX)
                    $display("  actual %s", show(got));
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    int   cycle_count = 0;
    int   live_items = 0;
    int   item_gap_max = 3;

    arq_scoreboard board;

    arq_chan_if #(.T(in_item_t))   item_if ();
    arq_chan_if #(.T(result_t))    res_if ();
    arq_chan_if #(.T(cfg_write_t)) cfg_if ();

    two_channel_stop_wait_arq_sender #(
        .PAYLOAD_BYTES(SEGMENT_MAX)
    ) uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_in    (item_if),
        .result_out (res_if),
        .cfg        (cfg_if)
    );

    // Free-running clock, 8 ns period.
    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic in_item_t item_of(logic [1:0] cmd, logic ch, logic ok,
                                         logic [31:0] seq);
        in_item_t it;
        it.command = cmd;
        it.ack_channel = ch;
        it.ack_type_ok = ok;
        it.ack_seq = seq;
        return it;
    endfunction

    // Offer one item after a random gap and wait until the sender takes it.
    task automatic send_item(in_item_t it);
        int gap;
        gap = $urandom_range(0, item_gap_max);
        if (gap > 0)
        begin
            item_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_if.valid <= 1'b1;
        item_if.data <= it;
        do @(posedge clk); while (!item_if.ready);
        if (it.command == CMD_START ? board.phase != PH_RUN
                                    : (it.command != CMD_UNUSED && board.phase == PH_RUN))
            live_items++;
        board.apply_item(it);
    endtask

    task automatic write_register(logic idx, logic [31:0] value);
        cfg_write_t w;
        w.index = idx;
        w.value = value;
        cfg_if.valid <= 1'b1;
        cfg_if.data <= w;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        board.set_register(w);
        @(posedge clk);
    endtask

    // Stop offering items and let every awaited result drain.
    task automatic quiesce();
        item_if.valid <= 1'b0;
        while (board.awaited.size() != 0)
            @(posedge clk);
        repeat (SETTLE_TICKS) @(posedge clk);
    endtask

    task automatic ack_good(int ch);
        send_item(item_of(CMD_ACK, ch[0], 1'b1, board.seq_of[ch]));
    endtask

    // Result side: random stalls, with stretches of none.
    initial
    begin : result_sink
        int stall;
        int stall_max;
        int mode_left;
        stall_max = 3;
        mode_left = 0;
        res_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (mode_left == 0)
            begin
                stall_max = ($urandom_range(0, 2) == 0) ? 0 : 3;
                mode_left = $urandom_range(20, 80);
            end
            mode_left--;
            stall = $urandom_range(0, stall_max);
            if (stall > 0)
            begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk); while (!res_if.valid);
            board.check_result(res_if.data);
        end
    end

    initial
    begin : stimulus
        int budget;
        int pick;
        int ch;
        logic [31:0] len_pick;

        rst_n <= 1'b0;
        item_if.valid <= 1'b0;
        item_if.data <= '0;
        cfg_if.valid <= 1'b0;
        cfg_if.data <= '0;
        board = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Items while idle are dropped; a start with zero length fails.
        send_item(item_of(CMD_TICK, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_item(item_of(CMD_ACK, 1'b0, 1'b1, 32'h0));
        send_item(item_of(CMD_UNUSED, 1'b1, 1'b0, 32'h5A5A_A5A5));
        send_item(item_of(CMD_START, 1'b0, 1'b0, 32'h0));
        send_item(item_of(CMD_ACK, 1'b1, 1'b1, 32'h0));

        // Single one-byte segment with a zero timeout.
        quiesce();
        write_register(REG_STREAM_LENGTH, 32'd1);
        write_register(REG_TIMEOUT_TICKS, 32'd0);
        send_item(item_of(CMD_START, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_item(item_of(CMD_TICK, 1'b0, 1'b0, 32'h0));
        ack_good(0);

        // Both channels expire together, then an ack on an idle channel.
        quiesce();
        write_register(REG_STREAM_LENGTH, 32'd3000);
        write_register(REG_TIMEOUT_TICKS, 32'd1);
        send_item(item_of(CMD_START, 1'b0, 1'b0, 32'h0));
        send_item(item_of(CMD_TICK, 1'b0, 1'b0, 32'h0));
        ack_good(1);
        send_item(item_of(CMD_START, 1'b1, 1'b1, 32'h0));
        send_item(item_of(CMD_UNUSED, 1'b0, 1'b1, 32'h0));
        ack_good(0);
        ack_good(0);

        // Longest stream: wrong type, wrong sequence, then a lowered length.
        quiesce();
        write_register(REG_STREAM_LENGTH, 32'hFFFF_FFFF);
        write_register(REG_TIMEOUT_TICKS, 32'hFFFF);
        send_item(item_of(CMD_START, 1'b0, 1'b0, 32'h0));
        send_item(item_of(CMD_ACK, 1'b0, 1'b0, 32'h0));
        send_item(item_of(CMD_START, 1'b0, 1'b0, 32'h0));
        send_item(item_of(CMD_ACK, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_item(item_of(CMD_START, 1'b0, 1'b0, 32'h0));
        ack_good(0);
        quiesce();
        write_register(REG_STREAM_LENGTH, 32'd100);
        ack_good(1);
        ack_good(0);

        // Random transfers, mostly well formed with some broken acks.
        while (live_items < 1050)
        begin
            quiesce();
            item_gap_max = ($urandom_range(0, 3) == 0) ? 0 : 3;
            case ($urandom_range(0, 19))
                0: len_pick = 32'd0;
                1: len_pick = SEGMENT_MAX * $urandom_range(1, 4);
                2: len_pick = 32'hFFFF_FFFF - $urandom_range(0, 3000);
                3: len_pick = $urandom;
                default: len_pick = $urandom_range(1, 6000);
            endcase
            write_register(REG_STREAM_LENGTH, len_pick);
            if ($urandom_range(0, 9) < 6)
            begin
                case ($urandom_range(0, 9))
                    0: write_register(REG_TIMEOUT_TICKS, 32'hFFFF);
                    1: write_register(REG_TIMEOUT_TICKS, $urandom_range(1, 65535));
                    2: write_register(REG_TIMEOUT_TICKS, 32'd1);
                    default: write_register(REG_TIMEOUT_TICKS, $urandom_range(2, 5));
                endcase
            end
            if ($urandom_range(0, 9) == 0)
                send_item(item_of($urandom_range(0, 1) ? CMD_ACK : CMD_TICK,
                                  1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                                  $urandom));
            send_item(item_of(CMD_START, 1'($urandom_range(0, 1)),
                              1'($urandom_range(0, 1)), $urandom));
            budget = $urandom_range(8, 60);
            while (board.phase == PH_RUN && budget > 0)
            begin
                budget--;
                if (board.busy[0] && board.busy[1])
                    ch = $urandom_range(0, 1);
                else
                    ch = board.busy[1] ? 1 : 0;
                pick = $urandom_range(0, 99);
                if (pick < 55)
                    ack_good(ch);
                else if (pick < 85)
                    send_item(item_of(CMD_TICK, 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)), $urandom));
                else if (pick < 88)
                    send_item(item_of(CMD_ACK, ch[0], 1'b1, ($urandom_range(0, 1) == 0)
                                      ? board.seq_of[ch] ^ (32'h1 << $urandom_range(0, 31))
                                      : $urandom));
                else if (pick < 90)
                    send_item(item_of(CMD_ACK, ch[0], 1'b0, board.seq_of[ch]));
                else if (pick < 92)
                    send_item(item_of(CMD_ACK, ~ch[0], 1'b1, board.seq_of[1 - ch]));
                else if (pick < 95)
                    send_item(item_of(CMD_START, 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)), $urandom));
                else if (pick < 97)
                    send_item(item_of(CMD_UNUSED, 1'($urandom_range(0, 1)),
                                      1'($urandom_range(0, 1)), $urandom));
                else
                begin
                    // Change the stream length while segments are outstanding.
                    quiesce();
                    if ($urandom_range(0, 1) == 0)
                        write_register(REG_STREAM_LENGTH,
                                       $urandom_range(0, board.next_offset));
                    else
                        write_register(REG_STREAM_LENGTH,
                                       board.next_offset + $urandom_range(1, 5000));
                end
            end
            if (board.phase == PH_RUN)
                send_item(item_of(CMD_ACK, 1'b0, 1'b0, $urandom));
        end

        quiesce();
        if (board.errors == 0 && board.awaited.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule
